// ----- hdl/rrts_pkg.sv -----
package rrts_pkg;

  // Field widths of the item channels.
  localparam int KIND_W    = 3;
  localparam int CPU_W     = 3;
  localparam int TASK_ID_W = 6;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  // Default sizes of the task tables and the CPU set.
  localparam int DEFAULT_MAX_TASKS = 64;
  localparam int DEFAULT_MAX_CPUS  = 8;

  // Configuration register reset values.
  localparam logic [CPU_W-1:0]     BOOT_CPU_RESET = 3'd0;
  localparam logic [TASK_ID_W-1:0] IDLE_ID_RESET  = 6'd2;

  // Configuration register indexes (address bit 2).
  localparam logic CFG_BOOT_CPU = 1'b0;
  localparam logic CFG_IDLE_ID  = 1'b1;

  // Event kinds.
  localparam logic [KIND_W-1:0] K_ENQUEUE = 3'd0;
  localparam logic [KIND_W-1:0] K_YIELD   = 3'd1;
  localparam logic [KIND_W-1:0] K_BLOCK   = 3'd2;
  localparam logic [KIND_W-1:0] K_WAKE    = 3'd3;
  localparam logic [KIND_W-1:0] K_FLAG    = 3'd4;
  localparam logic [KIND_W-1:0] K_PREEMPT = 3'd5;
  localparam logic [KIND_W-1:0] K_EXIT    = 3'd6;
  localparam logic [KIND_W-1:0] K_START   = 3'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_START = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_CUR   = 2'd3;

  // Task states.
  typedef logic [1:0] task_state_t;
  localparam task_state_t TS_DEAD    = 2'd0;
  localparam task_state_t TS_READY   = 2'd1;
  localparam task_state_t TS_RUNNING = 2'd2;
  localparam task_state_t TS_BLOCKED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [CPU_W-1:0]     cpu;
    logic [TASK_ID_W-1:0] task_id;
  } sched_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 switched;
    logic [TASK_ID_W-1:0] prev_task;
    logic [TASK_ID_W-1:0] next_task;
    logic [TASK_ID_W-1:0] assigned_id;
    logic [TASK_ID_W-1:0] running_task;
    logic                 preempt_pending;
    logic [COUNT_W-1:0]   task_count;
  } sched_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init1;
    logic init2;
    logic load;
    logic rd1;
    logic rd2;
    logic exec;
    logic wr2;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_wr2;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/rrts_ram.sv -----
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/rrts_ctrl.sv -----
module rrts_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   reinit,
  input  logic                   event_valid,
  input  rrts_pkg::dp_status_t   status,
  output logic                   event_stall,
  output rrts_pkg::ctrl_cmd_t    cmd
);
  import rrts_pkg::*;

  localparam logic [2:0] S_INIT1 = 3'd0;
  localparam logic [2:0] S_INIT2 = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_RD2   = 3'd4;
  localparam logic [2:0] S_EXEC  = 3'd5;
  localparam logic [2:0] S_WR2   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  // Items are taken only in the idle state and never during a re-init request.
  assign event_stall = (state != S_IDLE) || reinit;
  assign accept      = event_valid && !event_stall;

  // Sequencer: init, then per item the read states RD1 and RD2, execute and an optional second write.
  always_comb begin
    state_next = state;
    priority if (reinit) begin
      state_next = S_INIT1;
    end else begin
      unique case (state)
        S_INIT1: state_next = S_INIT2;
        S_INIT2: state_next = S_IDLE;
        S_IDLE:  state_next = accept ? S_RD1 : S_IDLE;
        S_RD1:   state_next = S_RD2;
        S_RD2:   state_next = S_EXEC;
        S_EXEC: begin
          if (status.out_free) begin
            state_next = status.need_wr2 ? S_WR2 : S_IDLE;
          end
        end
        S_WR2:   state_next = S_IDLE;
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT1;
    end else begin
      state <= state_next;
    end
  end

  // Command decode.
  always_comb begin
    cmd.init1 = (state == S_INIT1);
    cmd.init2 = (state == S_INIT2);
    cmd.load  = accept;
    cmd.rd1   = (state == S_RD1);
    cmd.rd2   = (state == S_RD2);
    cmd.exec  = (state == S_EXEC) && status.out_free;
    cmd.wr2   = (state == S_WR2);
  end

endmodule

// ----- hdl/rrts_dp.sv -----
module rrts_dp #(
  parameter int MAX_TASKS = rrts_pkg::DEFAULT_MAX_TASKS,
  parameter int MAX_CPUS  = rrts_pkg::DEFAULT_MAX_CPUS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              reinit,
  input  logic [rrts_pkg::CPU_W-1:0]        boot_cpu,
  input  logic [rrts_pkg::TASK_ID_W-1:0]    idle_task_id,
  input  rrts_pkg::ctrl_cmd_t               cmd,
  output rrts_pkg::dp_status_t              status,
  input  rrts_pkg::sched_in_t               event_item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output rrts_pkg::sched_out_t              result_item
);
  import rrts_pkg::*;

  localparam int TASK_AW   = $clog2(MAX_TASKS);
  localparam int CPU_AW    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int SUM_W     = TASK_AW + 1;
  localparam int NF_W      = TASK_ID_W + 1;
  localparam int CPU_CMP_W = CPU_W + 1;
  localparam int ID_LIMIT  = (MAX_TASKS < 64) ? MAX_TASKS : 64;

  function automatic logic id_in_range(input logic [TASK_ID_W-1:0] id);
    return (MAX_TASKS > 64) || ({1'b0, id} < NF_W'(MAX_TASKS));
  endfunction

  function automatic logic cpu_in_range(input logic [CPU_W-1:0] c);
    return (MAX_CPUS >= 8) || ({1'b0, c} < CPU_CMP_W'(MAX_CPUS));
  endfunction

  // Latched item.
  sched_in_t item_r;

  // Control state.
  logic [TASK_AW-1:0]  head;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    live;
  logic [NF_W-1:0]     next_free;
  logic                sched_running;
  logic [MAX_CPUS-1:0] flags;
  logic [MAX_CPUS-1:0] cur_valid;
  logic [MAX_TASKS-1:0] st_valid;

  // Memory ports.
  logic                 cur_we;
  logic [CPU_AW-1:0]    cur_waddr;
  logic [TASK_ID_W-1:0] cur_wdata;
  logic [TASK_ID_W-1:0] cur_rdata;
  logic                 cur_vld_r;
  logic                 st_we;
  logic [TASK_ID_W-1:0] st_wid;
  task_state_t          st_wdata;
  logic [TASK_ID_W-1:0] st_rid;
  task_state_t          st_rdata;
  logic                 st_vld_r;
  logic                 q_we;
  logic [TASK_AW-1:0]   q_waddr;
  logic [TASK_ID_W-1:0] q_wdata;
  logic [TASK_ID_W-1:0] q_rdata;

  // Item-level decode.
  logic                 cpu_ok;
  logic [CPU_AW-1:0]    cidx;
  logic [TASK_ID_W-1:0] prev;
  task_state_t          st_rd;
  task_state_t          st_tid_r;
  logic                 q_full;
  logic [SUM_W-1:0]     tail_sum;
  logic [TASK_AW-1:0]   tail;
  logic [TASK_AW-1:0]   head_inc;

  // Execute-step results.
  logic [STATUS_W-1:0]  x_status;
  logic [TASK_ID_W-1:0] x_nxt;
  logic [TASK_ID_W-1:0] x_assigned;
  logic [TASK_ID_W-1:0] x_enq_id;
  logic                 x_w1_en;
  logic [TASK_ID_W-1:0] x_w1_id;
  task_state_t          x_w1_st;
  logic                 x_w2_en;
  logic                 x_push;
  logic [TASK_ID_W-1:0] x_push_id;
  logic                 x_pop;
  logic                 x_sched;
  logic                 x_start;
  logic                 x_eff_run;
  logic                 x_requeue;
  logic                 x_flag_set;
  logic                 x_flag_clr;
  logic                 x_live_inc;
  logic                 x_free_inc;
  logic                 x_run_set;
  logic                 x_cur_we;
  logic [TASK_ID_W-1:0] x_cand;
  logic [TASK_ID_W-1:0] x_pop_val;
  logic                 x_flag_after;
  logic [CNT_W-1:0]     live_next;
  logic [CNT_W-1:0]     fill_next;
  logic [TASK_ID_W-1:0] w2_id_r;

  // Item register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= event_item;
    end
  end

  assign cpu_ok = cpu_in_range(item_r.cpu);
  assign cidx   = CPU_AW'(item_r.cpu);

  // Current task per CPU: memory plus one valid bit per CPU.
  rrts_ram #(.WIDTH(TASK_ID_W), .DEPTH(MAX_CPUS)) u_cur (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (cidx),
    .rdata (cur_rdata)
  );

  always_ff @(posedge clk) begin
    cur_vld_r <= cpu_ok && cur_valid[cidx];
  end

  assign prev = cur_vld_r ? cur_rdata : '0;

  // Task state table: the first read cycle looks up the named task, later cycles the
  // current task of the CPU.
  assign st_rid = cmd.rd1 ? item_r.task_id : prev;

  rrts_ram #(.WIDTH(2), .DEPTH(MAX_TASKS)) u_st (
    .clk   (clk),
    .we    (st_we),
    .waddr (TASK_AW'(st_wid)),
    .wdata (st_wdata),
    .raddr (TASK_AW'(st_rid)),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    st_vld_r <= id_in_range(st_rid) && st_valid[TASK_AW'(st_rid)];
    if (cmd.rd2) begin
      st_tid_r <= st_rd;
    end
  end

  assign st_rd = st_vld_r ? st_rdata : TS_DEAD;

  // Ready queue ring.
  rrts_ram #(.WIDTH(TASK_ID_W), .DEPTH(MAX_TASKS)) u_q (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head),
    .rdata (q_rdata)
  );

  assign q_full   = (fill >= CNT_W'(MAX_TASKS));
  assign tail_sum = SUM_W'(head) + SUM_W'(fill);
  assign tail     = (tail_sum >= SUM_W'(MAX_TASKS)) ? TASK_AW'(tail_sum - SUM_W'(MAX_TASKS))
                                                     : TASK_AW'(tail_sum);
  assign head_inc = (head == TASK_AW'(MAX_TASKS - 1)) ? '0 : head + 1'b1;

  // Event decode and the schedule step.
  always_comb begin
    x_status   = STAT_OK;
    x_nxt      = '0;
    x_assigned = '0;
    x_enq_id   = item_r.task_id;
    x_w1_en    = 1'b0;
    x_w1_id    = '0;
    x_w1_st    = TS_DEAD;
    x_w2_en    = 1'b0;
    x_push     = 1'b0;
    x_push_id  = '0;
    x_pop      = 1'b0;
    x_sched    = 1'b0;
    x_start    = 1'b0;
    x_eff_run  = 1'b0;
    x_requeue  = (prev != '0) && (st_rd == TS_RUNNING);
    x_flag_set = 1'b0;
    x_flag_clr = 1'b0;
    x_live_inc = 1'b0;
    x_free_inc = 1'b0;
    x_run_set  = 1'b0;
    x_cur_we   = 1'b0;
    x_cand     = '0;
    x_pop_val  = '0;

    priority if (item_r.kind == K_ENQUEUE) begin
      priority if (q_full || (live >= CNT_W'(MAX_TASKS))) begin
        x_status = STAT_FULL;
      end else if ((item_r.task_id == '0) && (next_free >= NF_W'(ID_LIMIT))) begin
        x_status = STAT_FULL;
      end else if (!id_in_range(item_r.task_id)) begin
        x_status = STAT_FULL;
      end else begin
        if (item_r.task_id == '0) begin
          x_enq_id   = next_free[TASK_ID_W-1:0];
          x_free_inc = 1'b1;
        end
        x_w1_en    = 1'b1;
        x_w1_id    = x_enq_id;
        x_w1_st    = TS_READY;
        x_push     = 1'b1;
        x_push_id  = x_enq_id;
        x_live_inc = 1'b1;
        x_assigned = x_enq_id;
      end
    end else if (item_r.kind == K_WAKE) begin
      if (st_tid_r == TS_BLOCKED) begin
        if (q_full) begin
          x_status = STAT_FULL;
        end else begin
          x_w1_en   = 1'b1;
          x_w1_id   = item_r.task_id;
          x_w1_st   = TS_READY;
          x_push    = 1'b1;
          x_push_id = item_r.task_id;
        end
      end
    end else if (!cpu_ok) begin
      x_status = STAT_NO_CUR;
    end else begin
      unique case (item_r.kind)
        K_YIELD: begin
          if ((prev != '0) && q_full) begin
            x_status = STAT_FULL;
          end else begin
            x_push    = (prev != '0);
            x_push_id = prev;
            x_sched   = 1'b1;
            x_eff_run = (st_rd == TS_RUNNING);
          end
        end
        K_BLOCK: begin
          x_w1_en = (prev != '0);
          x_w1_id = prev;
          x_w1_st = TS_BLOCKED;
          x_sched = 1'b1;
        end
        K_FLAG: begin
          x_flag_set = 1'b1;
        end
        K_PREEMPT: begin
          if (sched_running && x_requeue && q_full) begin
            x_status = STAT_FULL;
          end else begin
            x_flag_clr = 1'b1;
            if (sched_running) begin
              if (prev == '0) begin
                x_status = STAT_NO_CUR;
              end else begin
                x_w1_en   = x_requeue;
                x_w1_id   = prev;
                x_w1_st   = TS_READY;
                x_push    = x_requeue;
                x_push_id = prev;
                x_sched   = 1'b1;
              end
            end
          end
        end
        K_EXIT: begin
          if (prev == '0) begin
            x_status = STAT_NO_CUR;
          end else begin
            x_w1_en = 1'b1;
            x_w1_id = prev;
            x_w1_st = TS_DEAD;
            x_sched = 1'b1;
          end
        end
        K_START: begin
          x_start = 1'b1;
        end
        default: begin
          x_status = STAT_OK;
        end
      endcase
    end

    // Head of the queue after this step's push; an empty queue hands back the pushed id.
    if (fill == '0) begin
      x_pop_val = x_push ? x_push_id : '0;
    end else begin
      x_pop_val = q_rdata;
    end

    // Schedule step: pop, else keep a running current task, else take the idle task.
    if (x_sched) begin
      x_pop  = (fill != '0) || x_push;
      x_cand = x_pop_val;
      if (x_cand == '0) begin
        if (!((prev != '0) && x_eff_run)) begin
          x_cand = idle_task_id;
        end
      end
      if (x_cand != '0) begin
        x_w2_en = 1'b1;
        if (x_cand != prev) begin
          x_cur_we = 1'b1;
          x_nxt    = x_cand;
        end
      end
    end

    // Start pops the queue and runs what it finds.
    if (x_start) begin
      x_pop  = (fill != '0);
      x_cand = (fill != '0) ? q_rdata : '0;
      if (x_cand == '0) begin
        x_status = STAT_NO_START;
      end else begin
        x_run_set = 1'b1;
        x_w1_en   = 1'b1;
        x_w1_id   = x_cand;
        x_w1_st   = TS_RUNNING;
        x_cur_we  = 1'b1;
        x_nxt     = (x_cand != prev) ? x_cand : '0;
      end
    end
  end

  assign x_flag_after = x_flag_set ? 1'b1 :
                        x_flag_clr ? 1'b0 :
                        (cpu_ok && flags[cidx]);

  assign live_next = live + CNT_W'(x_live_inc);

  assign status.need_wr2 = x_w2_en;
  assign status.out_free = !result_valid || !result_stall;

  // State table write port: init entries, then first and second writes of an item.
  always_comb begin
    st_we    = 1'b0;
    st_wid   = '0;
    st_wdata = TS_DEAD;
    priority if (cmd.init1) begin
      st_we    = 1'b1;
      st_wid   = TASK_ID_W'(1);
      st_wdata = TS_RUNNING;
    end else if (cmd.init2) begin
      st_we    = (idle_task_id != '0) && id_in_range(idle_task_id);
      st_wid   = idle_task_id;
      st_wdata = TS_READY;
    end else if (cmd.exec) begin
      st_we    = x_w1_en && id_in_range(x_w1_id);
      st_wid   = x_w1_id;
      st_wdata = x_w1_st;
    end else if (cmd.wr2) begin
      st_we    = id_in_range(w2_id_r);
      st_wid   = w2_id_r;
      st_wdata = TS_RUNNING;
    end
  end

  // Current-task and queue write ports.
  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = cidx;
    cur_wdata = x_cand;
    q_we      = 1'b0;
    q_waddr   = tail;
    q_wdata   = x_push_id;
    priority if (cmd.init1) begin
      cur_we    = cpu_in_range(boot_cpu);
      cur_waddr = CPU_AW'(boot_cpu);
      cur_wdata = TASK_ID_W'(1);
      q_we      = (idle_task_id != '0);
      q_wdata   = idle_task_id;
    end else if (cmd.exec) begin
      cur_we = x_cur_we;
      q_we   = x_push;
    end
  end

  assign fill_next = fill + CNT_W'(q_we) - CNT_W'(cmd.exec && x_pop);

  // Scheduler bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      head          <= '0;
      fill          <= '0;
      live          <= CNT_W'(2);
      next_free     <= NF_W'(3);
      sched_running <= 1'b0;
      flags         <= '0;
      cur_valid     <= '0;
      st_valid      <= '0;
    end else begin
      if (cmd.init1 || cmd.exec) begin
        fill <= fill_next;
      end
      if (cmd.exec) begin
        if (x_pop) begin
          head <= head_inc;
        end
        live      <= live_next;
        next_free <= next_free + NF_W'(x_free_inc);
        if (x_run_set) begin
          sched_running <= 1'b1;
        end
        if (cpu_ok && (x_flag_set || x_flag_clr)) begin
          flags[cidx] <= x_flag_set;
        end
      end
      if (cur_we) begin
        cur_valid[cur_waddr] <= 1'b1;
      end
      if (st_we) begin
        st_valid[TASK_AW'(st_wid)] <= 1'b1;
      end
    end
  end

  // Second write target.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      w2_id_r <= x_cand;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.exec) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result_item.status          <= x_status;
      result_item.switched        <= (x_nxt != '0);
      result_item.prev_task       <= prev;
      result_item.next_task       <= x_nxt;
      result_item.assigned_id     <= x_assigned;
      result_item.running_task    <= !cpu_ok ? '0 : (x_cur_we ? x_cand : prev);
      result_item.preempt_pending <= cpu_ok && x_flag_after;
      result_item.task_count      <= COUNT_W'(live_next);
    end
  end

endmodule

// ----- hdl/round_robin_task_scheduler.sv -----
// Channel   Handshake                       Payload
// event     event_valid / event_stall       event_item  (kind, cpu, task_id)
// result    result_valid / result_stall     result_item (status ... task_count)
// config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// An accepted item passes the states RD1, RD2 and EXEC before the next one can be
// accepted, and WR2 as well when the schedule step writes a second entry of the task
// state memory, whose single write port makes WR2 needed. The result is registered in EXEC.
// After rst, and after a write of boot_cpu, the init states run with event_stall high.
// A new item is accepted while a result waits; it then holds before its result stage.
module round_robin_task_scheduler #(
  parameter int MAX_TASKS = rrts_pkg::DEFAULT_MAX_TASKS,
  parameter int MAX_CPUS  = rrts_pkg::DEFAULT_MAX_CPUS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 event_valid,
  output logic                 event_stall,
  input  rrts_pkg::sched_in_t  event_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output rrts_pkg::sched_out_t result_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rrts_pkg::*;

  logic [CPU_W-1:0]     boot_cpu;
  logic [TASK_ID_W-1:0] idle_task_id;
  logic                 cfg_wr;
  logic                 reinit;
  ctrl_cmd_t            cmd;
  dp_status_t           status;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign reinit = cfg_wr && (paddr[2] == CFG_BOOT_CPU);

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_cpu     <= BOOT_CPU_RESET;
      idle_task_id <= IDLE_ID_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_BOOT_CPU) begin
        boot_cpu <= pwdata[CPU_W-1:0];
      end else begin
        idle_task_id <= pwdata[TASK_ID_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == CFG_BOOT_CPU) ? 32'(boot_cpu) : 32'(idle_task_id);

  rrts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .reinit      (reinit),
    .event_valid (event_valid),
    .status      (status),
    .event_stall (event_stall),
    .cmd         (cmd)
  );

  rrts_dp #(.MAX_TASKS(MAX_TASKS), .MAX_CPUS(MAX_CPUS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .reinit       (reinit),
    .boot_cpu     (boot_cpu),
    .idle_task_id (idle_task_id),
    .cmd          (cmd),
    .status       (status),
    .event_item   (event_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

`ifndef SYNTHESIS
  // A switch always names a task to run.
  a_switch_names_task: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.switched == (result_item.next_task != '0)))
    else $error("switched disagrees with next_task");

  // A failed event never switches tasks.
  a_error_no_switch: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_item.status != STAT_OK)) |-> !result_item.switched)
    else $error("switch reported with an error status");

  // An id is handed out only by a successful enqueue.
  a_assigned_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_item.assigned_id != '0)) |-> (result_item.status == STAT_OK))
    else $error("assigned id with an error status");

  // Writing boot_cpu starts the init sequence, which holds off items.
  a_reinit_stalls: assert property (@(posedge clk) disable iff (rst)
    reinit |=> event_stall)
    else $error("items accepted during re-init");
`endif

endmodule

// ----- bench/tb_round_robin_task_scheduler.sv -----
module tb_round_robin_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam int TASK_SLOTS   = DEFAULT_MAX_TASKS;
  localparam int CPU_SLOTS    = DEFAULT_MAX_CPUS;
  localparam int ID_SPACE     = 1 << TASK_ID_W;
  localparam int FRESH_LIMIT  = (TASK_SLOTS < ID_SPACE) ? TASK_SLOTS : ID_SPACE;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 165;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT [2]  = '{300, 900};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 event_valid = 1'b0;
  logic                 event_stall;
  sched_in_t            event_item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  sched_out_t           result_item;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Scheduler state as the block should hold it.
  logic [TASK_ID_W-1:0] ready_ring [TASK_SLOTS];
  int unsigned          ring_head;
  int unsigned          ring_fill;
  task_state_t          task_state [TASK_SLOTS];
  logic [TASK_ID_W-1:0] cpu_task [CPU_SLOTS];
  logic                 cpu_resched [CPU_SLOTS];
  logic                 sched_started;
  int unsigned          fresh_id;
  int unsigned          live_tasks;
  logic [CPU_W-1:0]     cfg_boot_cpu;
  logic [TASK_ID_W-1:0] cfg_idle_id;

  sched_in_t            pending_events [$];
  sched_out_t           result_forecast [$];
  sched_out_t           want;
  bit                   ev_fire = 1'b0;
  bit                   steady = 1'b0;
  int                   tx_gap = 0;
  int                   rx_wait = 0;
  int                   hold_left = 0;
  int                   hold_idx = 0;
  int                   results_seen = 0;
  int                   fail_count = 0;
  int                   cycle_count = 0;

  round_robin_task_scheduler uut (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_item   (event_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ready queue helpers: a ring that silently refuses a push when full.
  function automatic bit ring_full();
    return ring_fill >= TASK_SLOTS;
  endfunction

  function automatic void ring_push(logic [TASK_ID_W-1:0] id);
    if (!ring_full()) begin
      ready_ring[(ring_head + ring_fill) % TASK_SLOTS] = id;
      ring_fill++;
    end
  endfunction

  function automatic logic [TASK_ID_W-1:0] ring_pop();
    logic [TASK_ID_W-1:0] id;
    if (ring_fill == 0) return '0;
    id = ready_ring[ring_head];
    ring_head = (ring_head + 1) % TASK_SLOTS;
    ring_fill--;
    return id;
  endfunction

  // State after init: task 1 runs on the boot CPU and the idle task is queued.
  function automatic void sched_reinit();
    foreach (ready_ring[i]) ready_ring[i] = '0;
    foreach (task_state[i]) task_state[i] = TS_DEAD;
    foreach (cpu_task[i]) begin
      cpu_task[i] = '0;
      cpu_resched[i] = 1'b0;
    end
    ring_head = 0;
    ring_fill = 0;
    sched_started = 1'b0;
    task_state[1] = TS_RUNNING;
    if (cfg_idle_id != 0) begin
      task_state[cfg_idle_id] = TS_READY;
      ring_push(cfg_idle_id);
    end
    cpu_task[cfg_boot_cpu] = 1;
    fresh_id = 3;
    live_tasks = 2;
  endfunction

  // Pop the queue for a CPU; returns the newly chosen task, zero when unchanged.
  function automatic logic [TASK_ID_W-1:0] pick_next(logic [CPU_W-1:0] c);
    logic [TASK_ID_W-1:0] cur;
    logic [TASK_ID_W-1:0] nxt;
    cur = cpu_task[c];
    nxt = ring_pop();
    if (nxt == 0) begin
      if (cur != 0 && task_state[cur] == TS_RUNNING) return '0;
      nxt = cfg_idle_id;
      if (nxt == 0) return '0;
    end
    if (nxt == cur) begin
      task_state[cur] = TS_RUNNING;
      return '0;
    end
    task_state[nxt] = TS_RUNNING;
    cpu_task[c] = nxt;
    return nxt;
  endfunction

  // Applies one event to the predicted state and returns the result it should give.
  function automatic sched_out_t sched_step(sched_in_t ev);
    sched_out_t           r;
    logic [TASK_ID_W-1:0] prev;
    logic [TASK_ID_W-1:0] nxt;
    logic [TASK_ID_W-1:0] id;
    logic                 requeue;
    r = '0;
    r.status = STAT_OK;
    prev = cpu_task[ev.cpu];
    nxt = '0;
    case (ev.kind)
      K_ENQUEUE: begin
        if (ring_full() || live_tasks >= TASK_SLOTS) begin
          r.status = STAT_FULL;
        end else if (ev.task_id == 0 && fresh_id >= FRESH_LIMIT) begin
          r.status = STAT_FULL;
        end else begin
          id = ev.task_id;
          if (id == 0) begin
            id = fresh_id[TASK_ID_W-1:0];
            fresh_id++;
          end
          task_state[id] = TS_READY;
          ring_push(id);
          live_tasks++;
          r.assigned_id = id;
        end
      end
      K_WAKE: begin
        if (task_state[ev.task_id] == TS_BLOCKED) begin
          if (ring_full()) begin
            r.status = STAT_FULL;
          end else begin
            task_state[ev.task_id] = TS_READY;
            ring_push(ev.task_id);
          end
        end
      end
      K_YIELD: begin
        if (prev != 0 && ring_full()) begin
          r.status = STAT_FULL;
        end else begin
          if (prev != 0) ring_push(prev);
          nxt = pick_next(ev.cpu);
        end
      end
      K_BLOCK: begin
        if (prev != 0) task_state[prev] = TS_BLOCKED;
        nxt = pick_next(ev.cpu);
      end
      K_FLAG: begin
        cpu_resched[ev.cpu] = 1'b1;
      end
      K_PREEMPT: begin
        requeue = prev != 0 && task_state[prev] == TS_RUNNING;
        if (sched_started && requeue && ring_full()) begin
          r.status = STAT_FULL;
        end else begin
          cpu_resched[ev.cpu] = 1'b0;
          if (sched_started) begin
            if (prev == 0) begin
              r.status = STAT_NO_CUR;
            end else begin
              if (requeue) begin
                task_state[prev] = TS_READY;
                ring_push(prev);
              end
              nxt = pick_next(ev.cpu);
            end
          end
        end
      end
      K_EXIT: begin
        if (prev == 0) begin
          r.status = STAT_NO_CUR;
        end else begin
          task_state[prev] = TS_DEAD;
          nxt = pick_next(ev.cpu);
        end
      end
      K_START: begin
        id = ring_pop();
        if (id == 0) begin
          r.status = STAT_NO_START;
        end else begin
          sched_started = 1'b1;
          task_state[id] = TS_RUNNING;
          cpu_task[ev.cpu] = id;
          if (id != prev) nxt = id;
        end
      end
    endcase
    r.switched = nxt != 0;
    r.prev_task = prev;
    r.next_task = nxt;
    r.running_task = cpu_task[ev.cpu];
    r.preempt_pending = cpu_resched[ev.cpu];
    r.task_count = live_tasks[COUNT_W-1:0];
    return r;
  endfunction

  function automatic sched_in_t make_event(logic [KIND_W-1:0] kind, logic [CPU_W-1:0] cpu,
                                           logic [TASK_ID_W-1:0] task_id);
    sched_in_t ev;
    ev.kind = kind;
    ev.cpu = cpu;
    ev.task_id = task_id;
    return ev;
  endfunction

  // Flood phases lean on enqueue to run the tables and the queue full.
  function automatic sched_in_t random_event(bit flood);
    sched_in_t   ev;
    int unsigned roll;
    ev.cpu = $urandom_range(0, CPU_SLOTS - 1);
    ev.task_id = $urandom_range(0, ID_SPACE - 1);
    roll = $urandom_range(0, 99);
    if (flood) begin
      if (roll < 55) ev.kind = K_ENQUEUE;
      else if (roll < 70) ev.kind = K_YIELD;
      else if (roll < 80) ev.kind = K_WAKE;
      else if (roll < 88) ev.kind = K_BLOCK;
      else ev.kind = $urandom_range(0, 7);
    end else begin
      if (roll < 18) ev.kind = K_ENQUEUE;
      else if (roll < 28) ev.kind = K_START;
      else if (roll < 43) ev.kind = K_YIELD;
      else if (roll < 53) ev.kind = K_BLOCK;
      else if (roll < 66) ev.kind = K_WAKE;
      else if (roll < 76) ev.kind = K_FLAG;
      else if (roll < 88) ev.kind = K_PREEMPT;
      else ev.kind = K_EXIT;
    end
    // Bias task ids toward those that are likely live.
    roll = $urandom_range(0, 99);
    if (ev.kind == K_ENQUEUE && roll < 60) ev.task_id = '0;
    else if (roll < 75) ev.task_id = $urandom_range(1, 20);
    return ev;
  endfunction

  task automatic check_field(string field, logic [COUNT_W-1:0] exp_val,
                             logic [COUNT_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, got_val);
      fail_count++;
    end
  endtask

  // Register write: setup cycle, then access cycle; the predictor follows at the write edge.
  task automatic cfg_write(logic idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == CFG_BOOT_CPU) begin
      cfg_boot_cpu = value[CPU_W-1:0];
      sched_reinit();
    end else begin
      cfg_idle_id = value[TASK_ID_W-1:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || event_valid || result_forecast.size() != 0)
      @(posedge clk);
  endtask

  // Sender: presents the next item after a random gap, holding it until accepted.
  always @(negedge clk) begin
    logic nv;
    if (!rst) begin
      nv = event_valid;
      if (event_valid && ev_fire) begin
        nv = 1'b0;
        tx_gap = steady ? 0 : $urandom_range(0, 15);
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_events.size() != 0) begin
          event_item <= pending_events.pop_front();
          nv = 1'b1;
        end
      end
      event_valid <= nv;
    end
  end

  // Receiver: stalls for a random count after each item, and twice for a long stretch.
  always @(negedge clk) begin
    if (!rst && hold_idx < 2 && results_seen >= HOLD_AT[hold_idx]) begin
      hold_idx++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Check results first, then predict for an item accepted at this edge.
  always @(posedge clk) begin
    if (rst) begin
      ev_fire = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        rx_wait = steady ? 0 : $urandom_range(0, 15);
        if (result_forecast.size() == 0) begin
          $error("result item with nothing expected: %h", result_item);
          fail_count++;
        end else begin
          want = result_forecast.pop_front();
          check_field("status", want.status, result_item.status);
          check_field("switched", want.switched, result_item.switched);
          check_field("prev_task", want.prev_task, result_item.prev_task);
          check_field("next_task", want.next_task, result_item.next_task);
          check_field("assigned_id", want.assigned_id, result_item.assigned_id);
          check_field("running_task", want.running_task, result_item.running_task);
          check_field("preempt_pending", want.preempt_pending, result_item.preempt_pending);
          check_field("task_count", want.task_count, result_item.task_count);
        end
      end
      ev_fire = event_valid && !event_stall;
      if (ev_fire) result_forecast.push_back(sched_step(event_item));
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [CPU_W-1:0]     boot;
    logic [TASK_ID_W-1:0] idle;
    bit                   idle_first;
    cfg_boot_cpu = BOOT_CPU_RESET;
    cfg_idle_id = IDLE_ID_RESET;
    sched_reinit();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed opening on the reset settings: boot CPU 0, idle task 2.
    pending_events.push_back(make_event(K_YIELD, 0, 0));
    pending_events.push_back(make_event(K_BLOCK, 0, 0));
    pending_events.push_back(make_event(K_WAKE, 0, 2));
    pending_events.push_back(make_event(K_WAKE, 0, 2));
    pending_events.push_back(make_event(K_EXIT, 5, 0));
    pending_events.push_back(make_event(K_FLAG, 3, 0));
    pending_events.push_back(make_event(K_PREEMPT, 3, 0));
    pending_events.push_back(make_event(K_ENQUEUE, 2, 0));
    pending_events.push_back(make_event(K_ENQUEUE, 4, 63));
    pending_events.push_back(make_event(K_ENQUEUE, 1, 3));
    pending_events.push_back(make_event(K_START, 7, 0));
    pending_events.push_back(make_event(K_START, 7, 0));
    pending_events.push_back(make_event(K_FLAG, 7, 0));
    pending_events.push_back(make_event(K_PREEMPT, 7, 0));
    pending_events.push_back(make_event(K_PREEMPT, 6, 0));
    pending_events.push_back(make_event(K_YIELD, 6, 0));
    pending_events.push_back(make_event(K_BLOCK, 5, 0));
    pending_events.push_back(make_event(K_EXIT, 7, 0));
    pending_events.push_back(make_event(K_YIELD, 0, 0));
    pending_events.push_back(make_event(K_START, 1, 0));
    pending_events.push_back(make_event(K_ENQUEUE, 0, 1));
    pending_events.push_back(make_event(K_FLAG, 0, 0));
    pending_events.push_back(make_event(K_PREEMPT, 0, 0));
    wait_idle();

    // Random phases, each on its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          idle = 63;
          boot = 7;
          idle_first = 1'b1;
        end
        1: begin
          idle = 0;
          boot = 3;
          idle_first = 1'b1;
        end
        2: begin
          idle = 1;
          boot = 0;
          idle_first = 1'b0;
        end
        default: begin
          idle = $urandom_range(0, ID_SPACE - 1);
          boot = $urandom_range(0, CPU_SLOTS - 1);
          idle_first = $urandom_range(0, 1);
        end
      endcase
      if (idle_first) cfg_write(CFG_IDLE_ID, 32'(idle));
      cfg_write(CFG_BOOT_CPU, 32'(boot));
      if (!idle_first) cfg_write(CFG_IDLE_ID, 32'(idle));
      steady = (p == 2 || p == 5);
      // Start a few CPUs so the rest of the phase runs a live scheduler.
      if (p % 2 == 0) begin
        repeat (3) pending_events.push_back(make_event(K_START, $urandom_range(0, 7), 0));
      end
      repeat (PHASE_ITEMS) pending_events.push_back(random_event(p % 2 == 1));
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_forecast.size() != 0) begin
      $error("%0d result items never arrived", result_forecast.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
